// File: hw/rtl/cbq_pkg.sv
package cbq_pkg;

   // Sizes of the filter
   localparam int MAX_STAGES   = 8;
   localparam int SAMPLE_WIDTH = 24;
   localparam int COEF_WIDTH   = 24;
   localparam int DELAY_WIDTH  = 32;
   localparam int COEF_FRAC    = COEF_WIDTH - 3;
   localparam int NUM_COEFS    = 5;
   localparam int STAGE_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

   // Fixed field widths
   localparam int CFG_W        = 4;
   localparam int STAGE_SEL_W  = 3;
   localparam int COEF_SEL_W   = 3;
   localparam logic [CFG_W-1:0] STAGES_RESET = 4'd8;

   // Product and accumulator widths
   localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int RND_W  = PROD_W + 1 - COEF_FRAC;
   localparam int WIDE_W = (RND_W > DELAY_WIDTH) ? RND_W : DELAY_WIDTH;
   localparam int ACC_W  = WIDE_W + 2;

   // Stream packing
   localparam int STAGE_LSB     = SAMPLE_WIDTH;
   localparam int CSEL_LSB      = STAGE_LSB + STAGE_SEL_W;
   localparam int COEF_LSB      = CSEL_LSB + COEF_SEL_W;
   localparam int REQ_DATA_BITS = COEF_LSB + COEF_WIDTH;
   localparam int REQ_TDATA_W   = ((REQ_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;
   typedef logic signed [DELAY_WIDTH-1:0]  delay_type;
   typedef logic signed [RND_W-1:0]        rnd_type;
   typedef logic signed [ACC_W-1:0]        acc_type;
   typedef logic [STAGE_W-1:0]             stage_type;

   typedef enum logic {
      REQ_FILTER = 1'b0,
      REQ_COEF   = 1'b1
   } req_kind_type;

   typedef enum logic [COEF_SEL_W-1:0] {
      COEF_B0 = 3'd0,
      COEF_B1 = 3'd1,
      COEF_B2 = 3'd2,
      COEF_A1 = 3'd3,
      COEF_A2 = 3'd4
   } coef_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_CALC_Y,
      ST_MUL_Y,
      ST_WRITE,
      ST_DONE
   } seq_state_type;

   // Datapath strobes from the sequencer
   typedef struct packed {
      logic load_sample;
      logic mul_x;
      logic calc_y;
      logic mul_y;
      logic write_back;
      logic load_rsp;
   } dp_ctl_type;

   typedef struct packed {
      coef_type b0;
      coef_type b1;
      coef_type b2;
      coef_type a1;
      coef_type a2;
   } coef_row_type;

   typedef struct packed {
      logic       clip;
      sample_type value;
   } sat_sample_type;

   typedef struct packed {
      logic      clip;
      delay_type value;
   } sat_delay_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam delay_type  DELAY_MAX  = {1'b0, {(DELAY_WIDTH-1){1'b1}}};
   localparam delay_type  DELAY_MIN  = {1'b1, {(DELAY_WIDTH-1){1'b0}}};
   localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (COEF_FRAC - 1);

   // Product rounded half up to the sample fraction
   function automatic rnd_type round_product(input sample_type a, input coef_type c);
      logic signed [PROD_W-1:0] p;
      logic signed [PROD_W:0]   t;
      p = PROD_W'(a) * PROD_W'(c);
      t = (PROD_W+1)'(p) + ROUND_HALF;
      return $signed(t[PROD_W:COEF_FRAC]);
   endfunction

   function automatic sat_sample_type sat_sample(input acc_type v);
      sat_sample_type r;
      logic [ACC_W-SAMPLE_WIDTH:0] hi;
      hi = v[ACC_W-1:SAMPLE_WIDTH-1];
      r.clip = !((&hi) || !(|hi));
      if (r.clip) begin
         r.value = v[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         r.value = $signed(v[SAMPLE_WIDTH-1:0]);
      end
      return r;
   endfunction

   function automatic sat_delay_type sat_delay(input acc_type v);
      sat_delay_type r;
      logic [ACC_W-DELAY_WIDTH:0] hi;
      hi = v[ACC_W-1:DELAY_WIDTH-1];
      r.clip = !((&hi) || !(|hi));
      if (r.clip) begin
         r.value = v[ACC_W-1] ? DELAY_MIN : DELAY_MAX;
      end else begin
         r.value = $signed(v[DELAY_WIDTH-1:0]);
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/cascaded_biquad_df2t.sv
// Cascade of up to eight second-order IIR sections in transposed direct form II,
// Q1.23 samples and Q3.21 coefficients, products rounded half up, stage outputs
// saturated to 24 bits and delays to 32 bits; rsp_tuser flags any clipping in the
// sample. A filter transaction (req_tuser 0) runs the stages one after another,
// each through MUL_X, CALC_Y, MUL_Y and WRITE, on a shared bank of three
// multipliers, reading coefficients and delays from memories with registered reads
// and writing delays back; the next sample is taken only once the last result is
// loaded into an output register, where it then waits while the next sample is
// taken. A coefficient transaction (req_tuser 1) writes one coefficient, clears
// that stage's delays and returns no result; writes to an unused selector are
// dropped. The user must write the stage count register over the csr port only
// while the block is idle (not enforced); 0 runs one stage, above eight runs eight.
module cascaded_biquad_df2t
   import cbq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Requests
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // sample_in[23:0], stage_select[26:24], coef_select[29:27], coef_value[53:30]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic                   req_tuser,
   // Results
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // sample_out[23:0]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // clipped[0]
   output logic                   rsp_tuser,
   // Stage count register
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_W-1:0]       csr_data
);

   dp_ctl_type   dp_ctl;
   logic         mem_rd_en;
   stage_type    mem_rd_stage;
   stage_type    wb_stage;
   logic         coef_wr_en;
   stage_type    coef_wr_stage;
   coef_sel_type coef_wr_sel;
   coef_row_type coefs;
   delay_type    s1, s2, new_s1, new_s2;
   sample_type   rsp_sample;
   logic         rsp_clip;

   // Request fields
   sample_type               req_sample;
   coef_type                 req_coef;
   logic [STAGE_SEL_W-1:0]   req_stage;
   logic [COEF_SEL_W-1:0]    req_csel;

   assign req_sample = $signed(req_tdata[SAMPLE_WIDTH-1:0]);
   assign req_stage  = req_tdata[STAGE_LSB +: STAGE_SEL_W];
   assign req_csel   = req_tdata[CSEL_LSB +: COEF_SEL_W];
   assign req_coef   = $signed(req_tdata[COEF_LSB +: COEF_WIDTH]);

   cbq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_kind      (req_kind_type'(req_tuser)),
      .req_stage     (req_stage),
      .req_csel      (req_csel),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .ctl           (dp_ctl),
      .rd_en         (mem_rd_en),
      .rd_stage      (mem_rd_stage),
      .wb_stage      (wb_stage),
      .coef_wr_en    (coef_wr_en),
      .coef_wr_stage (coef_wr_stage),
      .coef_wr_sel   (coef_wr_sel)
   );

   cbq_coef_mem u_coef_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (coef_wr_en),
      .wr_stage (coef_wr_stage),
      .wr_sel   (coef_wr_sel),
      .wr_value (req_coef),
      .rd_en    (mem_rd_en),
      .rd_stage (mem_rd_stage),
      .rd_row   (coefs)
   );

   cbq_delay_mem u_delay_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (mem_rd_en),
      .rd_stage  (mem_rd_stage),
      .wr_en     (dp_ctl.write_back),
      .wr_stage  (wb_stage),
      .wr_s1     (new_s1),
      .wr_s2     (new_s2),
      .clr_en    (coef_wr_en),
      .clr_stage (coef_wr_stage),
      .rd_s1     (s1),
      .rd_s2     (s2)
   );

   cbq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (dp_ctl),
      .req_sample (req_sample),
      .coefs      (coefs),
      .s1         (s1),
      .s2         (s2),
      .new_s1     (new_s1),
      .new_s2     (new_s2),
      .rsp_sample (rsp_sample),
      .rsp_clip   (rsp_clip)
   );

   assign rsp_tdata = RSP_TDATA_W'($unsigned(rsp_sample));
   assign rsp_tuser = rsp_clip;

`ifndef ASSERT_OFF
   // A coefficient write never holds off the next request
   a_coef_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == REQ_COEF) |=> req_tready)
      else $error("request stalled after coefficient write");

   // A result only appears when the sequencer hands one over
   a_rsp_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(dp_ctl.load_rsp))
      else $error("result valid without a finished sample");

   // Delay read of the next stage never hits the entry being written back
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (dp_ctl.write_back && mem_rd_en) |-> (mem_rd_stage != wb_stage))
      else $error("delay read and write on the same stage");

   // No stage arithmetic while requests are being taken
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !(dp_ctl.mul_x || dp_ctl.calc_y || dp_ctl.mul_y || dp_ctl.write_back))
      else $error("stage work while idle");
`endif

endmodule

// File: hw/rtl/cbq_coef_mem.sv
module cbq_coef_mem
   import cbq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  stage_type    wr_stage,
   input  coef_sel_type wr_sel,
   input  coef_type     wr_value,
   input  logic         rd_en,
   input  stage_type    rd_stage,
   output coef_row_type rd_row
);

   // One row per stage, b0 in the lowest word
   logic [NUM_COEFS*COEF_WIDTH-1:0] mem [MAX_STAGES];
   logic [NUM_COEFS-1:0]            valid_ff [MAX_STAGES];
   logic [NUM_COEFS*COEF_WIDTH-1:0] row_ff;
   logic [NUM_COEFS-1:0]            row_vld_ff;

   // Coefficient rows, one word of a row written per transaction
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_stage][int'(wr_sel)*COEF_WIDTH +: COEF_WIDTH] <= wr_value;
      end
      if (rd_en) begin
         row_ff <= mem[rd_stage];
      end
   end

   // Written flags: an unwritten coefficient reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAX_STAGES; s++) begin
            valid_ff[s] <= '0;
         end
         row_vld_ff <= '0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_stage][wr_sel] <= 1'b1;
         end
         if (rd_en) begin
            row_vld_ff <= valid_ff[rd_stage];
         end
      end
   end

   assign rd_row.b0 = row_vld_ff[COEF_B0] ?
                      row_ff[int'(COEF_B0)*COEF_WIDTH +: COEF_WIDTH] : '0;
   assign rd_row.b1 = row_vld_ff[COEF_B1] ?
                      row_ff[int'(COEF_B1)*COEF_WIDTH +: COEF_WIDTH] : '0;
   assign rd_row.b2 = row_vld_ff[COEF_B2] ?
                      row_ff[int'(COEF_B2)*COEF_WIDTH +: COEF_WIDTH] : '0;
   assign rd_row.a1 = row_vld_ff[COEF_A1] ?
                      row_ff[int'(COEF_A1)*COEF_WIDTH +: COEF_WIDTH] : '0;
   assign rd_row.a2 = row_vld_ff[COEF_A2] ?
                      row_ff[int'(COEF_A2)*COEF_WIDTH +: COEF_WIDTH] : '0;

endmodule

// File: hw/rtl/cbq_delay_mem.sv
module cbq_delay_mem
   import cbq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      rd_en,
   input  stage_type rd_stage,
   input  logic      wr_en,
   input  stage_type wr_stage,
   input  delay_type wr_s1,
   input  delay_type wr_s2,
   input  logic      clr_en,
   input  stage_type clr_stage,
   output delay_type rd_s1,
   output delay_type rd_s2
);

   logic [2*DELAY_WIDTH-1:0] mem [MAX_STAGES];
   logic [MAX_STAGES-1:0]    valid_ff;
   logic [2*DELAY_WIDTH-1:0] rd_data_ff;
   logic                     rd_vld_ff;

   // Delay pair store, s2 in the upper half
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_stage] <= {wr_s2, wr_s1};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_stage];
      end
   end

   // Valid flags: cleared by reset and by a coefficient write to the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (clr_en) begin
            valid_ff[clr_stage] <= 1'b0;
         end else if (wr_en) begin
            valid_ff[wr_stage] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_stage];
         end
      end
   end

   assign rd_s1 = rd_vld_ff ? $signed(rd_data_ff[DELAY_WIDTH-1:0]) : '0;
   assign rd_s2 = rd_vld_ff ? $signed(rd_data_ff[2*DELAY_WIDTH-1:DELAY_WIDTH]) : '0;

endmodule

// File: hw/rtl/cbq_datapath.sv
module cbq_datapath
   import cbq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dp_ctl_type   ctl,
   input  sample_type   req_sample,
   input  coef_row_type coefs,
   input  delay_type    s1,
   input  delay_type    s2,
   output delay_type    new_s1,
   output delay_type    new_s2,
   output sample_type   rsp_sample,
   output logic         rsp_clip
);

   sample_type x_ff, x_in;
   rnd_type    p0_ff, p0_in;
   rnd_type    p1_ff, p1_in;
   rnd_type    p2_ff, p2_in;
   rnd_type    q1_ff, q1_in;
   rnd_type    q2_ff, q2_in;
   logic       clip_ff, clip_in;
   sample_type rsp_sample_ff, rsp_sample_in;
   logic       rsp_clip_ff, rsp_clip_in;

   rnd_type        m0, m1, m2;
   acc_type        y_sum, d1_sum, d2_sum;
   sat_sample_type y_sat;
   sat_delay_type  d1_sat, d2_sat;

   // Three multipliers: b0/b1/b2 against x, then a1/a2 against y
   assign m0 = round_product(x_ff, coefs.b0);
   assign m1 = round_product(x_ff, ctl.mul_y ? coefs.a1 : coefs.b1);
   assign m2 = round_product(x_ff, ctl.mul_y ? coefs.a2 : coefs.b2);

   // Stage output and new delays
   assign y_sum  = ACC_W'(p0_ff) + ACC_W'(s1);
   assign d1_sum = ACC_W'(p1_ff) - ACC_W'(q1_ff) + ACC_W'(s2);
   assign d2_sum = ACC_W'(p2_ff) - ACC_W'(q2_ff);
   assign y_sat  = sat_sample(y_sum);
   assign d1_sat = sat_delay(d1_sum);
   assign d2_sat = sat_delay(d2_sum);

   always_comb begin
      x_in          = x_ff;
      p0_in         = p0_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      q1_in         = q1_ff;
      q2_in         = q2_ff;
      clip_in       = clip_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_clip_in   = rsp_clip_ff;
      if (ctl.load_sample) begin
         x_in    = req_sample;
         clip_in = 1'b0;
      end
      if (ctl.mul_x) begin
         p0_in = m0;
         p1_in = m1;
         p2_in = m2;
      end
      // y replaces x; it feeds the next stage too
      if (ctl.calc_y) begin
         x_in    = y_sat.value;
         clip_in = clip_ff | y_sat.clip;
      end
      if (ctl.mul_y) begin
         q1_in = m1;
         q2_in = m2;
      end
      if (ctl.write_back) begin
         clip_in = clip_ff | d1_sat.clip | d2_sat.clip;
      end
      if (ctl.load_rsp) begin
         rsp_sample_in = x_ff;
         rsp_clip_in   = clip_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      p0_ff         <= p0_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      q1_ff         <= q1_in;
      q2_ff         <= q2_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_clip_ff   <= rsp_clip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= 1'b0;
      end else begin
         clip_ff <= clip_in;
      end
   end

   assign new_s1     = d1_sat.value;
   assign new_s2     = d2_sat.value;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_clip   = rsp_clip_ff;

endmodule

// File: hw/rtl/cbq_ctrl.sv
module cbq_ctrl
   import cbq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  req_kind_type           req_kind,
   input  logic [STAGE_SEL_W-1:0] req_stage,
   input  logic [COEF_SEL_W-1:0]  req_csel,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_W-1:0]       csr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output dp_ctl_type             ctl,
   output logic                   rd_en,
   output stage_type              rd_stage,
   output stage_type              wb_stage,
   output logic                   coef_wr_en,
   output stage_type              coef_wr_stage,
   output coef_sel_type           coef_wr_sel
);

   seq_state_type    state_ff, state_in;
   stage_type        stage_ff, stage_in;
   logic [CFG_W-1:0] stages_ff, stages_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic      req_take;
   logic      filter_take;
   logic      coef_ok;
   logic      at_last;
   logic      rsp_free;
   stage_type last_stage;

   assign req_take    = req_tvalid && req_tready;
   assign filter_take = req_take && (req_kind == REQ_FILTER);
   assign coef_ok     = (req_csel <= COEF_A2) && (int'(req_stage) < MAX_STAGES);
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign at_last     = (stage_ff == last_stage);

   // Stage count clamped to one..MAX_STAGES
   always_comb begin
      if (stages_ff == '0) begin
         last_stage = '0;
      end else if (int'(stages_ff) > MAX_STAGES) begin
         last_stage = STAGE_W'(MAX_STAGES - 1);
      end else begin
         last_stage = STAGE_W'(stages_ff - 1'b1);
      end
   end

   // Next state and stage counter
   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (filter_take) begin
               state_in = ST_MUL_X;
               stage_in = '0;
            end
         end
         ST_MUL_X:  state_in = ST_CALC_Y;
         ST_CALC_Y: state_in = ST_MUL_Y;
         ST_MUL_Y:  state_in = ST_WRITE;
         ST_WRITE: begin
            if (at_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL_X;
               stage_in = STAGE_W'(stage_ff + 1'b1);
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      ctl             = '0;
      rd_en           = 1'b0;
      rd_stage        = STAGE_W'(stage_ff + 1'b1);
      req_tready      = 1'b0;
      coef_wr_en      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready      = 1'b1;
            ctl.load_sample = filter_take;
            rd_en           = filter_take;
            rd_stage        = '0;
            coef_wr_en      = req_take && (req_kind == REQ_COEF) && coef_ok;
         end
         ST_MUL_X:  ctl.mul_x  = 1'b1;
         ST_CALC_Y: ctl.calc_y = 1'b1;
         ST_MUL_Y:  ctl.mul_y  = 1'b1;
         ST_WRITE: begin
            ctl.write_back = 1'b1;
            rd_en          = !at_last;
         end
         ST_DONE:   ctl.load_rsp = rsp_free;
         default:   ctl = '0;
      endcase
   end

   assign wb_stage      = stage_ff;
   assign coef_wr_stage = STAGE_W'(req_stage);
   assign coef_wr_sel   = coef_sel_type'(req_csel);

   // Result handshake and stage count register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      stages_in = csr_valid ? csr_data : stages_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_ff     <= '0;
         stages_ff    <= STAGES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         stages_ff    <= stages_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;

endmodule
